### sv/mts_pkg.sv
// Shared constants and types for the min-tracking stack.
package mts_pkg;

  localparam int unsigned Depth     = 1024;
  localparam int unsigned AddrWidth = $clog2(Depth);
  localparam int unsigned CntWidth  = $clog2(Depth + 1);
  localparam int unsigned WordWidth = 32;

  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);
  localparam logic [CntWidth-1:0] CapReset = CntWidth'(1024);

  // opcode carried on tuser
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  typedef logic signed [WordWidth-1:0] word_t;
  typedef logic [AddrWidth-1:0]        addr_t;
  typedef logic [CntWidth-1:0]         cnt_t;

  localparam word_t EmptyWord = '1;

  // one write and one read request towards a stack store
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    addr_t rd_addr;
  } ram_req_t;

endpackage

### sv/mts_ram.sv
// Single-write, single-read store for stack entries with registered read data.
module mts_ram
  import mts_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rd_data_o
);

  word_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_o <= mem[req_i.rd_addr];
  end

endmodule

### sv/min_tracking_stack.sv
// Top level of the min-tracking stack: control, cached tops and the result register.
// Results: registered; a result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the result output stalls; each operation touches only the cached top
// registers, and each store keeps its second entry prefetched through its read port.
// Reset: asynchronous, active low; stack empty, capacity 1024, no result pending.
// Store contents are not cleared; only entries below the count are ever used.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: capacity register
  input  logic         cfg_wr_en_i,
  input  logic [10:0]  cfg_wr_data_i,
  // input beats
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // [31:0] push_value
  input  logic         s_axis_tuser_i,   // [0] opcode (0 push, 1 pop)
  // result beats
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [79:0]  m_axis_tdata_o    // [31:0] top_value, [63:32] min_value,
                                         // [64] is_empty, [65] is_full,
                                         // [66] push_dropped, [77:67] entry_count,
                                         // [79:78] zero
);

  // Capacity register
  cnt_t cap_q;
  cnt_t eff_cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  // Saturate the capacity at the store depth
  assign eff_cap = (cap_q > DepthCnt) ? DepthCnt : cap_q;

  // Stack state: counts and cached tops. The stores hold every entry; the
  // read ports keep the entry just below each top ready in sec/msec.
  cnt_t  cnt_q, cnt_d;
  cnt_t  mcnt_q, mcnt_d;
  word_t top_q, top_d;
  word_t mtop_q, mtop_d;
  word_t sec, msec;

  ram_req_t vreq, mreq;

  logic  accept;
  logic  out_valid_q;
  logic  dropped;
  word_t push_val;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_val        = s_axis_tdata_i;

  always_comb begin
    cnt_d   = cnt_q;
    mcnt_d  = mcnt_q;
    top_d   = top_q;
    mtop_d  = mtop_q;
    dropped = 1'b0;
    vreq.wr_en   = 1'b0;
    vreq.wr_addr = cnt_q[AddrWidth-1:0];
    vreq.wr_data = push_val;
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = mcnt_q[AddrWidth-1:0];
    mreq.wr_data = push_val;

    if (accept) begin
      case (s_axis_tuser_i)
        OpPush: begin
          if (cnt_q >= eff_cap) begin
            // full: drop the push and flag it
            dropped = 1'b1;
          end else begin
            vreq.wr_en = 1'b1;
            cnt_d      = cnt_q + 1'b1;
            top_d      = push_val;
            // duplicates of the minimum go onto the min stack again
            if ((mcnt_q == '0 || push_val <= mtop_q) && mcnt_q < DepthCnt) begin
              mreq.wr_en = 1'b1;
              mcnt_d     = mcnt_q + 1'b1;
              mtop_d     = push_val;
            end
          end
        end
        OpPop: begin
          // pop on an empty stack is ignored
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
            top_d = sec;
            if (mcnt_q != '0 && top_q == mtop_q) begin
              mcnt_d = mcnt_q - 1'b1;
              mtop_d = msec;
            end
          end
        end
        default: ;
      endcase
    end

    // Prefetch the entry below the next top; never clashes with this write
    vreq.rd_addr = AddrWidth'(cnt_d - CntWidth'(2));
    mreq.rd_addr = AddrWidth'(mcnt_d - CntWidth'(2));
  end

  mts_ram u_value_ram (
    .clk_i     (clk_i),
    .req_i     (vreq),
    .rd_data_o (sec)
  );

  mts_ram u_min_ram (
    .clk_i     (clk_i),
    .req_i     (mreq),
    .rd_data_o (msec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mcnt_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      mcnt_q <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    mtop_q <= mtop_d;
  end

  // Result register: hold while the downstream stalls, load on each accepted beat
  word_t res_top_q, res_min_q;
  logic  res_empty_q, res_full_q, res_drop_q;
  cnt_t  res_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_top_q   <= (cnt_d != '0) ? top_d : EmptyWord;
      res_min_q   <= (mcnt_d != '0) ? mtop_d : EmptyWord;
      res_empty_q <= (cnt_d == '0);
      res_full_q  <= (cnt_d >= eff_cap);
      res_drop_q  <= dropped;
      res_cnt_q   <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_cnt_q, res_drop_q, res_full_q, res_empty_q,
                            res_min_q, res_top_q};

endmodule

### test/tb.sv
// Testbench for the min-tracking stack: directed and random push/pop beats checked against a local stack model.
module tb
  import mts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 1000;  // cycles without any beat or capacity write before giving up

  // one input beat waiting to be driven, with the idle cycles to insert ahead of it
  typedef struct {
    logic        op;
    word_t       value;
    int unsigned gap;
  } op_beat_t;

  // what the stack should report after one operation
  typedef struct {
    word_t top;
    word_t min_val;
    logic  empty;
    logic  full;
    logic  dropped;
    cnt_t  count;
  } stack_view_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        in_valid;
  logic        in_op;
  word_t       in_data;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready;
  logic [79:0] m_data;

  op_beat_t    op_queue[$];    // beats still to be driven
  stack_view_t view_queue[$];  // stack views still to come back from the block
  int unsigned waited;         // idle cycles spent ahead of the front beat
  int unsigned stall_left;     // cycles the result side still holds tready low
  int unsigned quiet = 0;      // consecutive cycles without any beat or write
  int unsigned mismatches = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // local copy of the stack state
  word_t val_stk[Depth];
  word_t min_stk[Depth];
  int    val_cnt = 0;
  int    min_cnt = 0;
  cnt_t  cap_reg = CapReset;

  always #5 clk = ~clk;

  min_tracking_stack DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_op),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // Apply one operation to the local stack and return the view it leaves behind.
  function automatic stack_view_t stack_apply(logic op, word_t x);
    stack_view_t v;
    int          lim;
    lim = (cap_reg > Depth) ? Depth : int'(cap_reg);  // capacity saturates at the depth
    v.dropped = 1'b0;
    if (op == OpPush) begin
      if (val_cnt >= lim) begin
        v.dropped = 1'b1;
      end else begin
        val_stk[val_cnt] = x;
        val_cnt++;
        // equal values go onto the min stack too, so duplicate minima survive a pop
        if (min_cnt == 0 || x <= min_stk[min_cnt-1]) begin
          min_stk[min_cnt] = x;
          min_cnt++;
        end
      end
    end else if (val_cnt > 0) begin
      // pop on an empty stack leaves everything as it is
      if (min_cnt > 0 && val_stk[val_cnt-1] == min_stk[min_cnt-1]) min_cnt--;
      val_cnt--;
    end
    v.top     = (val_cnt > 0) ? val_stk[val_cnt-1] : EmptyWord;
    v.min_val = (min_cnt > 0) ? min_stk[min_cnt-1] : EmptyWord;
    v.empty   = (val_cnt == 0);
    v.full    = (val_cnt >= lim);
    v.count   = cnt_t'(val_cnt);
    return v;
  endfunction

  function automatic int unsigned pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: present the queued beats, honouring each beat's leading gap.
  always @(posedge clk or negedge rst_n) begin : drv
    op_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op    <= OpPush;
      in_data  <= '0;
      waited   <= 0;
    end else begin
      // predict at the edge that accepts the beat
      if (in_valid && s_ready) view_queue.push_back(stack_apply(in_op, in_data));
      if (!in_valid || s_ready) begin
        if (op_queue.size() != 0 && waited >= op_queue[0].gap) begin
          nxt = op_queue.pop_front();
          in_valid <= 1'b1;
          in_op    <= nxt.op;
          in_data  <= nxt.value;
          waited   <= 0;
        end else begin
          in_valid <= 1'b0;
          if (op_queue.size() != 0) waited <= waited + 1;
        end
      end
    end
  end

  // Monitor: take result beats with random back-pressure and compare with the oldest view.
  always @(posedge clk or negedge rst_n) begin : mon
    stack_view_t want;
    int unsigned hold;
    if (!rst_n) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (m_valid && m_ready) begin
        if (view_queue.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, m_data);
          mismatches++;
        end else begin
          want = view_queue.pop_front();
          check_field("top_value", want.top, m_data[31:0]);
          check_field("min_value", want.min_val, m_data[63:32]);
          check_field("is_empty", 32'(want.empty), 32'(m_data[64]));
          check_field("is_full", 32'(want.full), 32'(m_data[65]));
          check_field("push_dropped", 32'(want.dropped), 32'(m_data[66]));
          check_field("entry_count", 32'(want.count), 32'(m_data[77:67]));
        end
        // switch now and then between stalling and taking every beat
        if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
        hold = pause_len(out_calm);
      end else if (hold > 0) begin
        hold--;
      end
      stall_left <= hold;
      m_ready    <= (hold == 0);
    end
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet <= 0;
    else quiet <= quiet + 1;
  end

  task automatic queue_op(logic op, word_t v);
    op_beat_t b;
    if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
    b.op    = op;
    b.value = v;
    b.gap   = pause_len(in_calm);
    op_queue.push_back(b);
  endtask

  function automatic word_t value_draw();
    word_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = '0;
          default: v = EmptyWord;
        endcase
      end
      // narrow range, so equal values and repeated minima turn up often
      1, 2, 3, 4: v = word_t'($urandom_range(0, 8)) - 4;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // Hold until every queued beat has gone in and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || view_queue.size() != 0);
  endtask

  task automatic set_capacity(cnt_t v);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_reg      = v;
  endtask

  task automatic random_phase(int n, int unsigned push_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) queue_op(OpPush, value_draw());
      else queue_op(OpPop, $urandom);
    end
  endtask

  task automatic run_all();
    // extremes and duplicate minima at the reset capacity
    queue_op(OpPop, 32'h0000_0000);  // pop on empty
    queue_op(OpPush, 32'h7FFF_FFFF);
    queue_op(OpPush, 32'h8000_0000);
    queue_op(OpPush, 32'h8000_0000); // equal to the minimum
    queue_op(OpPush, EmptyWord);
    queue_op(OpPush, 32'h0000_0000);
    repeat (5) queue_op(OpPop, 32'hFFFF_FFFF);
    queue_op(OpPop, 32'h5A5A_A5A5);  // empty again
    // small capacity: fill, overflow, pop
    set_capacity(11'd3);
    queue_op(OpPush, 32'd3);
    queue_op(OpPush, 32'd1);
    queue_op(OpPush, 32'd2);
    queue_op(OpPush, 32'd9);         // dropped, stack full
    queue_op(OpPop, 32'hA5A5_5A5A);
    // capacity lowered below the count: pushes dropped, pops still work
    set_capacity(11'd1);
    queue_op(OpPush, 32'd4);
    queue_op(OpPop, 32'd0);
    queue_op(OpPush, 32'd6);
    queue_op(OpPop, 32'd0);
    // capacity zero: always full, every push dropped
    set_capacity(11'd0);
    queue_op(OpPush, 32'h8000_0000);
    queue_op(OpPop, 32'd0);

    // above the depth: fill to the top and beyond
    set_capacity(11'h7FF);
    random_phase(1100, 95);
    set_capacity(11'd1000);
    random_phase(250, 10);
    set_capacity(CapReset);
    random_phase(250, 50);
    set_capacity(11'd0);
    random_phase(40, 60);
    set_capacity(11'd1);
    random_phase(120, 50);
    set_capacity(11'd7);
    random_phase(150, 55);
    drain();                         // sender holds off until all results are in
    random_phase(150, 50);
    set_capacity(11'd1023);
    random_phase(150, 60);
    set_capacity(11'd2);
    random_phase(80, 50);

    drain();
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    fork
      run_all();
      wait (quiet >= QuietLimit);
    join_any
    if (quiet < QuietLimit && mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
